>>> rtl/pfsa_pkg.sv
// Shared types, widths and codes of the pair force scatter accumulator.
package pfsa_pkg;

    localparam int MAX_ATOMS_DEF = 1024;
    localparam int IDX_W         = 10;
    localparam int NBR_W         = 11;
    localparam int IN_W          = 24;
    localparam int PROD_W        = 48;
    localparam int TERM_W        = 32;
    localparam int ACC_W         = 40;
    // Wide enough to hold the largest allowed atom count itself.
    localparam int CNT_W         = 17;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_TERM,
        ST_CENTER,
        ST_NEIGHBOR
    } t_state;

    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
    } t_force;

    typedef struct packed {
        logic signed [TERM_W-1:0] x;
        logic signed [TERM_W-1:0] y;
        logic signed [TERM_W-1:0] z;
    } t_terms;

endpackage

>>> rtl/pfsa_store.sv
// Force store: one write port and one registered read port, one word per atom.
module pfsa_store
    import pfsa_pkg::*;
#(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF,
    localparam int AW = $clog2(MAX_ATOMS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_force        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_force        o_rdata
);

    t_force r_mem [MAX_ATOMS];
    t_force r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read word holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pfsa_term.sv
// Scale times derivative products and their rounding to Q16.16 terms.
module pfsa_term
    import pfsa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic signed [IN_W-1:0] i_du_value,
    input  logic signed [IN_W-1:0] i_deriv_x,
    input  logic signed [IN_W-1:0] i_deriv_y,
    input  logic signed [IN_W-1:0] i_deriv_z,
    output t_terms                 o_terms
);

    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(32768);

    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;
    logic signed [PROD_W-1:0] r_prod_z;
    logic signed [PROD_W-1:0] w_rnd_x;
    logic signed [PROD_W-1:0] w_rnd_y;
    logic signed [PROD_W-1:0] w_rnd_z;
    t_terms                   r_terms;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod_x <= PROD_W'(i_du_value) * PROD_W'(i_deriv_x);
            r_prod_y <= PROD_W'(i_du_value) * PROD_W'(i_deriv_y);
            r_prod_z <= PROD_W'(i_du_value) * PROD_W'(i_deriv_z);
        end
    end

    // Round to nearest, ties toward plus infinity; the result fits 32 bits.
    assign w_rnd_x = (r_prod_x + HALF_LSB) >>> 16;
    assign w_rnd_y = (r_prod_y + HALF_LSB) >>> 16;
    assign w_rnd_z = (r_prod_z + HALF_LSB) >>> 16;

    always_ff @(posedge i_clk) begin
        r_terms.x <= w_rnd_x[TERM_W-1:0];
        r_terms.y <= w_rnd_y[TERM_W-1:0];
        r_terms.z <= w_rnd_z[TERM_W-1:0];
    end

    assign o_terms = r_terms;

endmodule

>>> rtl/pfsa_update.sv
// Saturating add or subtract of the three terms into one force word.
module pfsa_update
    import pfsa_pkg::*;
(
    input  t_force i_base,
    input  t_terms i_terms,
    input  logic   i_sub,
    output t_force o_result
);

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  base,
        input logic signed [TERM_W-1:0] term,
        input logic                     sub
    );
        logic signed [TERM_W:0] t;
        logic signed [ACC_W:0]  s;
        logic signed [ACC_W-1:0] r;
        t = sub ? -(TERM_W+1)'(term) : (TERM_W+1)'(term);
        s = (ACC_W+1)'(base) + (ACC_W+1)'(t);
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        o_result.x = sat_add(i_base.x, i_terms.x, i_sub);
        o_result.y = sat_add(i_base.y, i_terms.y, i_sub);
        o_result.z = sat_add(i_base.z, i_terms.z, i_sub);
    end

endmodule

>>> rtl/pair_force_scatter_accumulate.sv
// Pair force scatter accumulator: sequencer, store and update path.
//
// Keeps one 40-bit x, y, z force word per atom in a single store with one
// write and one read port. An accumulate word adds du*d to the center
// atom and subtracts it from the neighbor atom through two read-modify-write
// passes over that port pair; no new word is taken until both are done. A
// read word returns the center force and clears its entry, and stalls while
// the previous result is still waiting at the output. An ignored accumulate
// (empty neighbor slot or an index at or past MAX_ATOMS) is simply dropped.
// After reset the block zeroes the store one entry per cycle and accepts no
// word until the last entry is cleared. A read result waits in an output
// register, so the next word can be taken while it is pending.
module pair_force_scatter_accumulate
    import pfsa_pkg::*;
#(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_operation,
    input  logic [IDX_W-1:0]        i_center_index,
    input  logic signed [NBR_W-1:0] i_neighbor_index,
    input  logic signed [IN_W-1:0]  i_du_value,
    input  logic signed [IN_W-1:0]  i_deriv_x,
    input  logic signed [IN_W-1:0]  i_deriv_y,
    input  logic signed [IN_W-1:0]  i_deriv_z,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [ACC_W-1:0] o_force_x,
    output logic signed [ACC_W-1:0] o_force_y,
    output logic signed [ACC_W-1:0] o_force_z
);

    localparam int AW = $clog2(MAX_ATOMS);
    localparam logic [CNT_W-1:0] LP_ATOMS = CNT_W'(MAX_ATOMS);
    localparam logic [AW-1:0]    LP_LAST  = AW'(MAX_ATOMS - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [AW-1:0] r_ctr_addr, n_ctr_addr;
    logic [AW-1:0] r_nbr_addr, n_nbr_addr;
    logic          r_same, n_same;
    logic          r_in_range, n_in_range;
    logic          r_out_valid, n_out_valid;
    t_force        r_out_force, n_out_force;
    t_force        r_fwd;

    logic          w_accept;
    logic          w_ctr_ok;
    logic          w_nbr_ok;
    logic          w_load;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_force        w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    t_force        w_rdata;
    t_terms        w_terms;
    t_force        w_base;
    t_force        w_upd;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_ctr_ok   = ({{(CNT_W-IDX_W){1'b0}}, i_center_index} < LP_ATOMS);
    assign w_nbr_ok   = !i_neighbor_index[NBR_W-1] &&
                        ({{(CNT_W-IDX_W){1'b0}}, i_neighbor_index[IDX_W-1:0]} < LP_ATOMS);

    // When center and neighbor coincide, the neighbor pass starts from the
    // value just written by the center pass.
    assign w_base = (r_state == ST_NEIGHBOR && r_same) ? r_fwd : w_rdata;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_ctr_addr  = r_ctr_addr;
        n_nbr_addr  = r_nbr_addr;
        n_same      = r_same;
        n_in_range  = r_in_range;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_force = r_out_force;
        w_load      = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_ctr_addr;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = AW'(i_center_index);
        unique case (r_state)
            ST_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LP_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_ctr_addr = AW'(i_center_index);
                    n_nbr_addr = AW'(i_neighbor_index[IDX_W-1:0]);
                    n_same     = (i_center_index == i_neighbor_index[IDX_W-1:0]);
                    n_in_range = w_ctr_ok;
                    if (i_operation == OP_READ) begin
                        w_re    = w_ctr_ok;
                        n_state = ST_READ;
                    end else if (w_ctr_ok && w_nbr_ok) begin
                        w_re    = 1'b1;
                        w_load  = 1'b1;
                        n_state = ST_TERM;
                    end
                end
            end
            ST_READ: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_force = r_in_range ? w_rdata : '0;
                    w_we        = r_in_range;
                    n_state     = ST_IDLE;
                end
            end
            ST_TERM: begin
                n_state = ST_CENTER;
            end
            ST_CENTER: begin
                w_we    = 1'b1;
                w_wdata = w_upd;
                w_re    = 1'b1;
                w_raddr = r_nbr_addr;
                n_state = ST_NEIGHBOR;
            end
            ST_NEIGHBOR: begin
                w_we    = 1'b1;
                w_waddr = r_nbr_addr;
                w_wdata = w_upd;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctr_addr  <= n_ctr_addr;
        r_nbr_addr  <= n_nbr_addr;
        r_same      <= n_same;
        r_in_range  <= n_in_range;
        r_out_force <= n_out_force;
        if (r_state == ST_CENTER) begin
            r_fwd <= w_upd;
        end
    end

    pfsa_store #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pfsa_term u_term (
        .i_clk      (i_clk),
        .i_load     (w_load),
        .i_du_value (i_du_value),
        .i_deriv_x  (i_deriv_x),
        .i_deriv_y  (i_deriv_y),
        .i_deriv_z  (i_deriv_z),
        .o_terms    (w_terms)
    );

    pfsa_update u_update (
        .i_base   (w_base),
        .i_terms  (w_terms),
        .i_sub    (r_state == ST_NEIGHBOR),
        .o_result (w_upd)
    );

    assign o_out_valid = r_out_valid;
    assign o_force_x   = r_out_force.x;
    assign o_force_y   = r_out_force.y;
    assign o_force_z   = r_out_force.z;

`ifndef SYNTHESIS
    a_center_then_neighbor: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CENTER) |=> (r_state == ST_NEIGHBOR)
    ) else $error("center update not followed by neighbor update");

    a_read_gives_word: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && (!r_out_valid || i_out_ready)) |=> o_out_valid
    ) else $error("finished read did not present a word");

    a_accum_no_word: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == OP_ACCUM && !o_out_valid) |=> !o_out_valid
    ) else $error("accumulate produced an output word");

    a_clear_exit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && r_clr_addr != LP_LAST) |=> (r_state == ST_CLEAR)
    ) else $error("clearing pass ended early");

    a_no_write_when_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_we
    ) else $error("store written while idle");
`endif

endmodule
